FILE: rtl/scs_pkg.sv
// ----------------------------------------------------------------------------
// scs_pkg
// Shared types and constants for the shadow call stack: frame layout, chain
// control and the sequencer's state encoding.
// ----------------------------------------------------------------------------
package scs_pkg;

  localparam int unsigned SCS_DEPTH = 64;
  localparam int unsigned ADDR_W    = 32;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    addr_t call_addr;
    addr_t ret_addr;
    addr_t sp;
    addr_t hash;
  } frame_t;

  // shift_up drops the top frame (ring rotate toward cell 0),
  // shift_down opens a slot at the top (ring rotate away from cell 0);
  // load_new puts the new frame in cell 0 instead of the wrapped one.
  typedef struct packed {
    logic shift_up;
    logic shift_down;
    logic load_new;
  } chain_ctl_t;

  typedef enum logic [1:0] {
    FUNC_PUSH    = 2'd0,
    FUNC_POP_PTR = 2'd1,
    FUNC_POP_RET = 2'd2,
    FUNC_ALIGN   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAIL,
    ST_STALE,
    ST_POP_RET,
    ST_SEARCH,
    ST_RESTORE,
    ST_REPORT
  } state_t;

endpackage

FILE: rtl/scs_cell.sv
// ----------------------------------------------------------------------------
// scs_cell
// One frame slot of the stack chain. Holds, takes its upper neighbor on a
// shift down, or its lower neighbor on a shift up.
// ----------------------------------------------------------------------------
module scs_cell (
  input  logic                clk,
  input  scs_pkg::chain_ctl_t ctl,
  input  scs_pkg::frame_t     from_above,
  input  scs_pkg::frame_t     from_below,
  output scs_pkg::frame_t     frame_q
);
  import scs_pkg::*;

  frame_t frame_r;
  frame_t frame_nxt;

  always_comb begin
    frame_nxt = frame_r;
    if (ctl.shift_up) begin
      frame_nxt = from_below;
    end else if (ctl.shift_down) begin
      frame_nxt = from_above;
    end
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
  end

  assign frame_q = frame_r;

endmodule

FILE: rtl/scs_chain.sv
// ----------------------------------------------------------------------------
// scs_chain
// Ring of DEPTH frame cells. Cell 0 is the top of stack; on a shift, frames
// rotate one cell per cycle, so frames past the live count are don't-care.
// ----------------------------------------------------------------------------
module scs_chain #(
  parameter int unsigned DEPTH = scs_pkg::SCS_DEPTH
) (
  input  logic                clk,
  input  scs_pkg::chain_ctl_t ctl,
  input  scs_pkg::frame_t     new_frame,
  output scs_pkg::frame_t     top_frame
);
  import scs_pkg::*;

  frame_t cell_q     [DEPTH];
  frame_t cell_above [DEPTH];
  frame_t cell_below [DEPTH];

  genvar k;
  generate
    for (k = 0; k < DEPTH; k++) begin : g_cell
      if (k == 0) begin : g_first
        assign cell_above[k] = ctl.load_new ? new_frame : cell_q[DEPTH-1];
      end else begin : g_mid_a
        assign cell_above[k] = cell_q[k-1];
      end
      if (k == DEPTH-1) begin : g_last
        assign cell_below[k] = cell_q[0];
      end else begin : g_mid_b
        assign cell_below[k] = cell_q[k+1];
      end

      scs_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .from_above (cell_above[k]),
        .from_below (cell_below[k]),
        .frame_q    (cell_q[k])
      );
    end
  endgenerate

  assign top_frame = cell_q[0];

endmodule

FILE: rtl/shadow_call_stack.sv
// ----------------------------------------------------------------------------
// shadow_call_stack
// Shadow call stack of up to DEPTH frames held in a rotating ring of cells,
// stepped by a sequencer that looks only at the top cell.
// ----------------------------------------------------------------------------
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+----------------------
//  input   | in_func, in_call_address, in_return_    | start && !busy
//          | address, in_stack_pointer               |
//  result  | out_depth, out_top_hash, out_top_call_  | out_valid, 1 cycle,
//          | address, out_top_return_address,        | cannot be stalled
//          | out_matched, out_overflow               |
//
// One frame is examined or moved per cycle at the top cell of the ring.
// Push: tail check, then stale frames are dropped one by one, then the push
// (a tail call pushes nothing). Align: stale frames dropped one by one. Pop to
// return: frames removed until one matches or none is left. Pop with pointer
// check: frames rotated past the top in search, rotated back when no truncate.
// busy is high from accept until the result beat; out_valid rises as busy
// falls, so the next beat may be accepted in the strobe cycle.
// Reset (rst_n low, synchronous) empties the stack; no clearing pass.
// ----------------------------------------------------------------------------
module shadow_call_stack #(
  parameter int unsigned DEPTH = scs_pkg::SCS_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           in_func,
  input  scs_pkg::addr_t                       in_call_address,
  input  scs_pkg::addr_t                       in_return_address,
  input  scs_pkg::addr_t                       in_stack_pointer,
  output logic                                 out_valid,
  output logic [$clog2(DEPTH+1)-1:0]           out_depth,
  output scs_pkg::addr_t                       out_top_hash,
  output scs_pkg::addr_t                       out_top_call_address,
  output scs_pkg::addr_t                       out_top_return_address,
  output logic                                 out_matched,
  output logic                                 out_overflow
);
  import scs_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH+1);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             matched_r, matched_nxt;
  logic             overflow_r, overflow_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             report;

  func_t            op_r;
  addr_t            ca_r, ra_r, sp_r;
  logic [CNT_W-1:0] out_depth_r;
  addr_t            out_hash_r, out_ca_r, out_ra_r;
  logic             out_matched_r, out_overflow_r;

  chain_ctl_t ctl;
  frame_t     new_frame;
  frame_t     top_frame;
  logic       accept;
  logic       live;
  logic       ra_hit;
  logic       sp_hit;
  logic       stale;

  assign accept = start && (state_r == ST_IDLE);
  assign live   = (count_r != '0);
  assign ra_hit = (top_frame.ret_addr == ra_r);
  assign sp_hit = (top_frame.sp == sp_r);
  assign stale  = live && (sp_r >= top_frame.sp);

  assign new_frame.call_addr = ca_r;
  assign new_frame.ret_addr  = ra_r;
  assign new_frame.sp        = sp_r;
  assign new_frame.hash      = live ? (ra_r ^ top_frame.hash) : ra_r;

  scs_chain #(.DEPTH(DEPTH)) u_chain (
    .clk       (clk),
    .ctl       (ctl),
    .new_frame (new_frame),
    .top_frame (top_frame)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    matched_nxt   = matched_r;
    overflow_nxt  = overflow_r;
    out_valid_nxt = 1'b0;
    report        = 1'b0;
    ctl           = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          idx_nxt      = '0;
          matched_nxt  = 1'b0;
          overflow_nxt = 1'b0;
          case (func_t'(in_func))
            FUNC_PUSH:    state_nxt = ST_TAIL;
            FUNC_POP_PTR: state_nxt = ST_SEARCH;
            FUNC_POP_RET: state_nxt = ST_POP_RET;
            FUNC_ALIGN:   state_nxt = ST_STALE;
            default:      state_nxt = ST_STALE;
          endcase
        end
      end
      ST_TAIL: begin
        // tail call: same frame, nothing to do
        state_nxt = (live && sp_hit) ? ST_REPORT : ST_STALE;
      end
      ST_STALE: begin
        if (stale) begin
          ctl.shift_up = 1'b1;
          count_nxt    = count_r - CNT_ONE;
        end else if (op_r == FUNC_PUSH) begin
          if (count_r >= CNT_FULL) begin
            overflow_nxt = 1'b1;
          end else begin
            ctl.shift_down = 1'b1;
            ctl.load_new   = 1'b1;
            count_nxt      = count_r + CNT_ONE;
          end
          state_nxt = ST_REPORT;
        end else begin
          state_nxt = ST_REPORT;
        end
      end
      ST_POP_RET: begin
        if (live) begin
          ctl.shift_up = 1'b1;
          count_nxt    = count_r - CNT_ONE;
          if (ra_hit) begin
            matched_nxt = 1'b1;
            state_nxt   = ST_REPORT;
          end
        end else begin
          state_nxt = ST_REPORT;
        end
      end
      ST_SEARCH: begin
        // idx_r frames have been rotated past the top so far
        if ((idx_r < count_r) && ra_hit) begin
          matched_nxt = 1'b1;
          if (sp_hit) begin
            ctl.shift_up = 1'b1;
            count_nxt    = count_r - idx_r - CNT_ONE;
            state_nxt    = ST_REPORT;
          end else begin
            state_nxt = (idx_r == '0) ? ST_REPORT : ST_RESTORE;
          end
        end else if (idx_r < count_r) begin
          ctl.shift_up = 1'b1;
          idx_nxt      = idx_r + CNT_ONE;
        end else begin
          state_nxt = (idx_r == '0) ? ST_REPORT : ST_RESTORE;
        end
      end
      ST_RESTORE: begin
        ctl.shift_down = 1'b1;
        idx_nxt        = idx_r - CNT_ONE;
        if (idx_r == CNT_ONE) begin
          state_nxt = ST_REPORT;
        end
      end
      ST_REPORT: begin
        report        = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      matched_r   <= 1'b0;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      matched_r   <= matched_nxt;
      overflow_r  <= overflow_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= func_t'(in_func);
      ca_r <= in_call_address;
      ra_r <= in_return_address;
      sp_r <= in_stack_pointer;
    end
    if (report) begin
      out_depth_r    <= count_r;
      out_hash_r     <= live ? top_frame.hash      : '0;
      out_ca_r       <= live ? top_frame.call_addr : '0;
      out_ra_r       <= live ? top_frame.ret_addr  : '0;
      out_matched_r  <= matched_r;
      out_overflow_r <= overflow_r;
    end
  end

  assign busy                   = (state_r != ST_IDLE);
  assign out_valid              = out_valid_r;
  assign out_depth              = out_depth_r;
  assign out_top_hash           = out_hash_r;
  assign out_top_call_address   = out_ca_r;
  assign out_top_return_address = out_ra_r;
  assign out_matched            = out_matched_r;
  assign out_overflow           = out_overflow_r;

  // ---- assertions ----
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("frame count above DEPTH");

  a_beat_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |-> (out_depth == CNT_FULL))
    else $error("overflow reported on a stack that is not full");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_depth == '0)) |-> (out_top_hash == '0))
    else $error("nonzero hash on empty stack");

endmodule

FILE: test/tb_shadow_call_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shadow_call_stack
// Self-checking bench for the shadow call stack. A short directed pass walks
// the tail-call, stale-frame, search and unwind cases; random call/return
// traffic with deep call bursts follows. Every result beat is checked against
// a frame-level model of the stack kept in a scoreboard.
// ----------------------------------------------------------------------------
module tb_shadow_call_stack;
  import scs_pkg::*;

  localparam int unsigned DEPTH_W = $clog2(SCS_DEPTH + 1);

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    addr_t              hash;
    addr_t              call_addr;
    addr_t              ret_addr;
    logic               matched;
    logic               overflow;
  } stack_view_t;

  class call_stack_scoreboard;
    frame_t        frames [SCS_DEPTH];
    int unsigned   n_frames;
    stack_view_t   pending_views [$];
    int unsigned   errors;
    int unsigned   op_count [4];
    int unsigned   n_matched, n_overflow, n_tail, peak_depth;

    function new();
      n_frames = 0;
      errors = 0;
      n_matched = 0;
      n_overflow = 0;
      n_tail = 0;
      peak_depth = 0;
      foreach (op_count[i]) op_count[i] = 0;
    endfunction

    function int unsigned depth_now();
      return n_frames;
    endfunction

    function frame_t frame_at(int unsigned idx);
      return frames[idx];
    endfunction

    function int unsigned pending();
      return pending_views.size();
    endfunction

    // pop frames whose pointer is at or below the current one (already returned)
    function void unwind_to(addr_t sp);
      while (n_frames > 0 && sp >= frames[n_frames-1].sp) n_frames--;
    endfunction

    function void note(func_t f, addr_t ca, addr_t ra, addr_t sp);
      stack_view_t v;
      int unsigned i;
      bit          hit;
      v = '0;
      hit = 1'b0;
      op_count[f]++;
      case (f)
        FUNC_PUSH: begin
          if (n_frames > 0 && sp == frames[n_frames-1].sp) begin
            n_tail++;
          end else begin
            unwind_to(sp);
            if (n_frames >= SCS_DEPTH) begin
              v.overflow = 1'b1;
            end else begin
              frames[n_frames].call_addr = ca;
              frames[n_frames].ret_addr  = ra;
              frames[n_frames].sp        = sp;
              frames[n_frames].hash      = (n_frames > 0) ? (ra ^ frames[n_frames-1].hash) : ra;
              n_frames++;
            end
          end
        end
        FUNC_POP_PTR: begin
          i = n_frames;
          while (i > 0 && !hit) begin
            if (frames[i-1].ret_addr == ra) begin
              hit = 1'b1;
              if (sp == frames[i-1].sp) n_frames = i - 1;
            end else begin
              i--;
            end
          end
          v.matched = hit;
        end
        FUNC_POP_RET: begin
          while (n_frames > 0 && !hit) begin
            hit = (frames[n_frames-1].ret_addr == ra);
            n_frames--;
          end
          v.matched = hit;
        end
        default: unwind_to(sp);
      endcase
      v.depth = n_frames[DEPTH_W-1:0];
      if (n_frames > 0) begin
        v.hash      = frames[n_frames-1].hash;
        v.call_addr = frames[n_frames-1].call_addr;
        v.ret_addr  = frames[n_frames-1].ret_addr;
      end
      if (v.matched) n_matched++;
      if (v.overflow) n_overflow++;
      if (n_frames > peak_depth) peak_depth = n_frames;
      pending_views.insert(pending_views.size(), v);
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task cmp(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
    endtask

    task check(stack_view_t got);
      stack_view_t want;
      if (pending_views.size() == 0) begin
        report("result beat with no operation outstanding");
        return;
      end
      want = pending_views.pop_front();
      cmp("depth", 32'(got.depth), 32'(want.depth));
      cmp("top_hash", got.hash, want.hash);
      cmp("top_call_address", got.call_addr, want.call_addr);
      cmp("top_return_address", got.ret_addr, want.ret_addr);
      cmp("matched", 32'(got.matched), 32'(want.matched));
      cmp("overflow", 32'(got.overflow), 32'(want.overflow));
    endtask

    task summary();
      $display("ran %0d ops: %0d push, %0d pointer pop, %0d return pop, %0d align",
               op_count[0] + op_count[1] + op_count[2] + op_count[3],
               op_count[FUNC_PUSH], op_count[FUNC_POP_PTR], op_count[FUNC_POP_RET],
               op_count[FUNC_ALIGN]);
      $display("%0d pops matched, %0d tail calls, %0d full-stack drops, peak depth %0d",
               n_matched, n_tail, n_overflow, peak_depth);
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_func;
  addr_t              in_call_address;
  addr_t              in_return_address;
  addr_t              in_stack_pointer;
  logic               out_valid;
  logic [DEPTH_W-1:0] out_depth;
  addr_t              out_top_hash;
  addr_t              out_top_call_address;
  addr_t              out_top_return_address;
  logic               out_matched;
  logic               out_overflow;

  call_stack_scoreboard sb;
  addr_t                ra_pool [8];
  bit                   no_idle;
  int unsigned          n_sent;

  shadow_call_stack #(.DEPTH(SCS_DEPTH)) u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_func                (in_func),
    .in_call_address        (in_call_address),
    .in_return_address      (in_return_address),
    .in_stack_pointer       (in_stack_pointer),
    .out_valid              (out_valid),
    .out_depth              (out_depth),
    .out_top_hash           (out_top_hash),
    .out_top_call_address   (out_top_call_address),
    .out_top_return_address (out_top_return_address),
    .out_matched            (out_matched),
    .out_overflow           (out_overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && sb != null)
      sb.check({out_depth, out_top_hash, out_top_call_address, out_top_return_address,
                out_matched, out_overflow});
  end

  function automatic int unsigned pick_gap();
    if (no_idle) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(5, 30);
  endfunction

  function automatic addr_t pick_ra();
    if ($urandom_range(0, 2) == 0) return ra_pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  // entered right after a falling edge; returns right after one
  task automatic send_beat(func_t f, addr_t ca, addr_t ra, addr_t sp);
    int unsigned gap;
    bit          taken;
    gap = pick_gap();
    taken = 1'b0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start             <= 1'b1;
    in_func           <= f;
    in_call_address   <= ca;
    in_return_address <= ra;
    in_stack_pointer  <= sp;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
    end
    sb.note(f, ca, ra, sp);
    n_sent++;
    @(negedge clk);
  endtask

  // nested calls with a falling stack pointer, past the stack's capacity
  task automatic deep_calls();
    int unsigned d, n;
    addr_t       sp;
    frame_t      top;
    d = sb.depth_now();
    sp = 32'hFFFF_F000;
    if (d > 0) begin
      top = sb.frame_at(d - 1);
      if (top.sp > 32'h0010_0000) sp = top.sp;
    end
    n = SCS_DEPTH + 2 - d + $urandom_range(0, 3);
    repeat (n) begin
      sp -= $urandom_range(4, 64);
      send_beat(FUNC_PUSH, $urandom(), pick_ra(), sp);
    end
  endtask

  task automatic random_op();
    int unsigned d, pick, idx;
    frame_t      fr, top;
    addr_t       sp, ra;
    d = sb.depth_now();
    pick = $urandom_range(0, 99);
    fr = '0;
    top = '0;
    if (d > 0) begin
      if ($urandom_range(0, 3) == 0) idx = $urandom_range(0, d - 1);
      else idx = d - 1 - $urandom_range(0, (d > 4) ? 3 : d - 1);
      fr = sb.frame_at(idx);
      top = sb.frame_at(d - 1);
    end
    if (pick < 10) begin
      send_beat(func_t'($urandom_range(0, 3)), $urandom(), $urandom(), $urandom());
    end else if (pick < 50) begin
      if (d == 0) sp = $urandom_range(32'h8000_0000, 32'hFFFF_FFFF);
      else if ($urandom_range(0, 9) == 0) sp = top.sp;             // tail call
      else if ($urandom_range(0, 9) == 0) sp = fr.sp + $urandom_range(0, 16);
      else sp = top.sp - $urandom_range(4, 512);
      send_beat(FUNC_PUSH, $urandom(), pick_ra(), sp);
    end else if (pick < 65) begin
      ra = (d > 0 && $urandom_range(0, 9) < 8) ? fr.ret_addr : pick_ra();
      send_beat(FUNC_POP_RET, $urandom(), ra, fr.sp + $urandom_range(0, 8));
    end else if (pick < 85) begin
      ra = (d > 0 && $urandom_range(0, 9) < 8) ? fr.ret_addr : pick_ra();
      sp = ($urandom_range(0, 9) < 7) ? fr.sp : $urandom();
      send_beat(FUNC_POP_PTR, $urandom(), ra, sp);
    end else begin
      if (d == 0) sp = $urandom();
      else if ($urandom_range(0, 1) == 0) sp = fr.sp + $urandom_range(0, 3);
      else sp = top.sp - $urandom_range(1, 64);                    // nothing stale
      send_beat(FUNC_ALIGN, $urandom(), $urandom(), sp);
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    start             = 1'b0;
    in_func           = FUNC_PUSH;
    in_call_address   = '0;
    in_return_address = '0;
    in_stack_pointer  = '0;
    no_idle           = 1'b0;
    n_sent            = 0;
    sb = new();
    ra_pool[0] = '0;
    ra_pool[1] = '1;
    for (int i = 2; i < 8; i++) ra_pool[i] = $urandom();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty stack: pops and align change nothing
    send_beat(FUNC_POP_PTR, '0, '0, '0);
    send_beat(FUNC_POP_RET, '1, '1, '1);
    send_beat(FUNC_ALIGN, '0, '0, '1);
    // push on empty skips the tail check; then the all-ones frame drops it
    send_beat(FUNC_PUSH, '0, '0, '0);
    send_beat(FUNC_PUSH, '1, '1, '1);
    send_beat(FUNC_PUSH, 32'h1111_0000, 32'h2222_0000, '1);        // tail call
    send_beat(FUNC_PUSH, 32'h1000_0010, 32'h0000_A1A1, 32'd1000);
    send_beat(FUNC_PUSH, 32'h1000_0020, 32'h0000_A2A2, 32'd900);
    send_beat(FUNC_PUSH, 32'h1000_0030, 32'h0000_A1A1, 32'd800);
    // search reaches below the top, pointer differs: no truncate
    send_beat(FUNC_POP_PTR, '0, 32'h0000_A2A2, 32'd123);
    send_beat(FUNC_POP_PTR, '0, 32'h0000_A1A1, 32'd800);
    send_beat(FUNC_POP_PTR, '0, 32'h0000_DEAD, 32'd900);
    // push above a live frame drops it first
    send_beat(FUNC_PUSH, 32'h1000_0040, 32'h0000_A3A3, 32'd950);
    send_beat(FUNC_ALIGN, '0, '0, 32'd960);
    send_beat(FUNC_ALIGN, '0, '0, 32'd999);
    send_beat(FUNC_POP_PTR, '0, 32'h0000_A1A1, 32'd1000);
    send_beat(FUNC_PUSH, 32'h1000_0050, 32'h0000_A3A3, 32'd500);
    send_beat(FUNC_PUSH, 32'h1000_0060, 32'h0000_A4A4, 32'd400);
    send_beat(FUNC_POP_RET, '0, 32'h0000_A3A3, 32'd400);
    send_beat(FUNC_POP_RET, '0, 32'h0000_1234, '0);                // no match, empties
    send_beat(FUNC_PUSH, '1, '0, '0);
    send_beat(FUNC_ALIGN, '1, '1, '0);

    while (n_sent < 1200) begin
      if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
      if ($urandom_range(0, 99) == 0) deep_calls();
      else random_op();
    end
    deep_calls();
    send_beat(FUNC_POP_PTR, '0, 32'h5A5A_5A5A, '0);                // full-depth search

    start <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    sb.summary();
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: shadow_call_stack.f
rtl/scs_pkg.sv
rtl/scs_cell.sv
rtl/scs_chain.sv
rtl/shadow_call_stack.sv
test/tb_shadow_call_stack.sv
